>>> src/lprsb_pkg.sv
// Shared types, constants and arithmetic helpers for the laser point transform.
package lprsb_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 48;

  // Midpoint and full scale of the screen in doubled raw units.
  localparam int Mid2   = 65535;
  localparam int Full2  = 131070;
  localparam int VisMin = 35;
  localparam int VisMax = 65500;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COS     = 3'd0,
    CFG_SIN     = 3'd1,
    CFG_CENTERX = 3'd2,
    CFG_CENTERY = 3'd3,
    CFG_SCALEX  = 3'd4,
    CFG_SCALEY  = 3'd5,
    CFG_COLOR   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [16:0] cos_angle;
    logic signed [16:0] sin_angle;
    logic signed [18:0] center_x2;
    logic signed [18:0] center_y2;
    logic signed [16:0] scale_x;
    logic signed [16:0] scale_y;
    logic        [47:0] color_rgb;
  } cfg_t;

  // Rotated point, already offset by the screen midpoint.
  typedef struct packed {
    logic signed [24:0] ux;
    logic signed [24:0] uy;
    logic               blank;
  } rot_res_t;

  // Divide by 32768 with truncation toward zero.
  function automatic logic signed [26:0] trunc_q15(input logic signed [41:0] p);
    logic signed [41:0] b;
    b = p + (p[41] ? 42'sd32767 : 42'sd0);
    return b[41:15];
  endfunction

endpackage

>>> src/lprsb_if.sv
// Handshake interfaces for the point, result and configuration channels.
interface lprsb_pt_if;
  logic        valid;
  logic        ready;
  logic [15:0] x_in;
  logic [15:0] y_in;
  logic        blank_in;
  modport source (output valid, x_in, y_in, blank_in, input ready);
  modport sink (input valid, x_in, y_in, blank_in, output ready);
endinterface

interface lprsb_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] x_out;
  logic [15:0] y_out;
  logic [15:0] red_out;
  logic [15:0] green_out;
  logic [15:0] blue_out;
  logic        blanked;
  modport source (output valid, x_out, y_out, red_out, green_out, blue_out, blanked,
                  input ready);
  modport sink (input valid, x_out, y_out, red_out, green_out, blue_out, blanked,
                output ready);
endinterface

interface lprsb_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/lprsb_cfg.sv
// Configuration register file.
module lprsb_cfg
  import lprsb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_valid_i,
  output logic                wr_ready_o,
  input  logic [CfgIdxW-1:0]  wr_index_i,
  input  logic [CfgDataW-1:0] wr_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign wr_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_valid_i) begin
      case (cfg_idx_e'(wr_index_i))
        CFG_COS:     cfg_d.cos_angle = wr_data_i[16:0];
        CFG_SIN:     cfg_d.sin_angle = wr_data_i[16:0];
        CFG_CENTERX: cfg_d.center_x2 = wr_data_i[18:0];
        CFG_CENTERY: cfg_d.center_y2 = wr_data_i[18:0];
        CFG_SCALEX:  cfg_d.scale_x   = wr_data_i[16:0];
        CFG_SCALEY:  cfg_d.scale_y   = wr_data_i[16:0];
        CFG_COLOR:   cfg_d.color_rgb = wr_data_i;
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cos_angle <= 17'sd32768;
      cfg_q.sin_angle <= 17'sd0;
      cfg_q.center_x2 <= 19'sd65535;
      cfg_q.center_y2 <= 19'sd65535;
      cfg_q.scale_x   <= 17'sd32768;
      cfg_q.scale_y   <= 17'sd32768;
      cfg_q.color_rgb <= '1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/lprsb_rot.sv
// Rotation about the configured center: offset, four products, truncate and sum.
module lprsb_rot
  import lprsb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] x_i,
  input  logic [15:0] y_i,
  input  logic        blank_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rot_res_t    out_o
);

  logic [2:0] v_q;
  logic [2:0] en;

  // A stage loads when it is empty or the stage after it moves on.
  assign en[2] = ~v_q[2] | out_ready_i;
  assign en[1] = ~v_q[1] | en[2];
  assign en[0] = ~v_q[0] | en[1];

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
    end
  end

  // Stage 1: offset from the rotation center.
  logic signed [19:0] dx_q, dy_q, dx_d, dy_d;
  logic               b1_q, b2_q;

  assign dx_d = $signed({3'b000, x_i, 1'b0}) - 20'(cfg_i.center_x2);
  assign dy_d = $signed({3'b000, y_i, 1'b0}) - 20'(cfg_i.center_y2);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
      b1_q <= blank_i;
    end
  end

  // Stage 2: the four rotation products.
  logic signed [36:0] pxc_q, pys_q, pxs_q, pyc_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      pxc_q <= dx_q * cfg_i.cos_angle;
      pys_q <= dy_q * cfg_i.sin_angle;
      pxs_q <= dx_q * cfg_i.sin_angle;
      pyc_q <= dy_q * cfg_i.cos_angle;
      b2_q  <= b1_q;
    end
  end

  // Stage 3: truncate each product, sum, and move the origin to the midpoint.
  logic signed [26:0] t_xc, t_ys, t_xs, t_yc;
  rot_res_t           res_q, res_d;

  assign t_xc = trunc_q15(42'(pxc_q));
  assign t_ys = trunc_q15(42'(pys_q));
  assign t_xs = trunc_q15(42'(pxs_q));
  assign t_yc = trunc_q15(42'(pyc_q));

  always_comb begin
    res_d.ux    = 25'(t_xc) - 25'(t_ys) + 25'(cfg_i.center_x2) - 25'(Mid2);
    res_d.uy    = 25'(t_xs) + 25'(t_yc) + 25'(cfg_i.center_y2) - 25'(Mid2);
    res_d.blank = b2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) res_q <= res_d;
  end

  assign out_o = res_q;

endmodule

>>> src/lprsb_scl.sv
// Scaling about the midpoint, clamp to the screen, window test and color.
module lprsb_scl
  import lprsb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  rot_res_t    in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] x_o,
  output logic [15:0] y_o,
  output logic [15:0] red_o,
  output logic [15:0] green_o,
  output logic [15:0] blue_o,
  output logic        blanked_o
);

  logic [2:0] v_q;
  logic [2:0] en;

  assign en[2] = ~v_q[2] | out_ready_i;
  assign en[1] = ~v_q[1] | en[2];
  assign en[0] = ~v_q[0] | en[1];

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
    end
  end

  // Stage 4: scale products.
  logic signed [41:0] px_q, py_q;
  logic               b4_q, b5_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      px_q <= in_i.ux * cfg_i.scale_x;
      py_q <= in_i.uy * cfg_i.scale_y;
      b4_q <= in_i.blank;
    end
  end

  // Stage 5: truncate, restore the midpoint, clamp and halve.
  logic signed [27:0] sx, sy;
  logic        [16:0] cx, cy;
  logic        [15:0] xo_q, yo_q;

  assign sx = 28'(trunc_q15(px_q)) + 28'(Mid2);
  assign sy = 28'(trunc_q15(py_q)) + 28'(Mid2);

  always_comb begin
    if (sx[27])                cx = '0;
    else if (sx > 28'(Full2))  cx = 17'(Full2);
    else                       cx = sx[16:0];
    if (sy[27])                cy = '0;
    else if (sy > 28'(Full2))  cy = 17'(Full2);
    else                       cy = sy[16:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      xo_q <= cx[16:1];
      yo_q <= cy[16:1];
      b5_q <= b4_q;
    end
  end

  // Stage 6: visible window test and color selection into the output register.
  logic        blank_d;
  logic [15:0] x_q, y_q, r_q, g_q, bl_q;
  logic        blanked_q;

  assign blank_d = b5_q
                 || (xo_q < 16'(VisMin)) || (xo_q > 16'(VisMax))
                 || (yo_q < 16'(VisMin)) || (yo_q > 16'(VisMax));

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      x_q       <= xo_q;
      y_q       <= yo_q;
      r_q       <= blank_d ? 16'd0 : cfg_i.color_rgb[47:32];
      g_q       <= blank_d ? 16'd0 : cfg_i.color_rgb[31:16];
      bl_q      <= blank_d ? 16'd0 : cfg_i.color_rgb[15:0];
      blanked_q <= blank_d;
    end
  end

  assign x_o       = x_q;
  assign y_o       = y_q;
  assign red_o     = r_q;
  assign green_o   = g_q;
  assign blue_o    = bl_q;
  assign blanked_o = blanked_q;

endmodule

>>> src/laser_point_rotate_scale_blank.sv
// Throughput: one point per cycle while the output is not stalled.
// Six pipeline stages, two of them multiplier stages, lead to the result beat.
// A stalled output holds the last stage; earlier stages keep filling bubbles behind it.
// Reset clears all stage valid bits and loads the default configuration
// (unit rotation about the screen middle, unit scale, full white color).
module laser_point_rotate_scale_blank
  import lprsb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  lprsb_cfg_if.sink   cfg_i,
  lprsb_pt_if.sink    pt_i,
  lprsb_res_if.source res_o
);

  cfg_t     cfg;
  rot_res_t rot_res;
  logic     rot_valid, scl_ready;

  lprsb_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_ready_o (cfg_i.ready),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  lprsb_rot u_rot (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (pt_i.valid),
    .in_ready_o  (pt_i.ready),
    .x_i         (pt_i.x_in),
    .y_i         (pt_i.y_in),
    .blank_i     (pt_i.blank_in),
    .out_valid_o (rot_valid),
    .out_ready_i (scl_ready),
    .out_o       (rot_res)
  );

  lprsb_scl u_scl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (rot_valid),
    .in_ready_o  (scl_ready),
    .in_i        (rot_res),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .x_o         (res_o.x_out),
    .y_o         (res_o.y_out),
    .red_o       (res_o.red_out),
    .green_o     (res_o.green_out),
    .blue_o      (res_o.blue_out),
    .blanked_o   (res_o.blanked)
  );

endmodule

>>> src/lprsb_chk.sv
// Port-level checks for the laser point transform, bound to the top level.
module lprsb_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] x_out_i,
  input logic [15:0] y_out_i,
  input logic [15:0] red_out_i,
  input logic [15:0] green_out_i,
  input logic [15:0] blue_out_i,
  input logic        blanked_i
);

  // A blanked beat never drives the laser.
  a_blank_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && blanked_i) |->
      (red_out_i == 16'd0 && green_out_i == 16'd0 && blue_out_i == 16'd0))
    else $error("blanked beat carries nonzero color");

  // An unblanked beat lies inside the visible window on both axes.
  a_lit_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !blanked_i) |->
      (x_out_i >= 16'd35 && x_out_i <= 16'd65500 &&
       y_out_i >= 16'd35 && y_out_i <= 16'd65500))
    else $error("lit beat outside the visible window");

  // A result beat that is not taken stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(x_out_i) && $stable(y_out_i) && $stable(blanked_i)))
    else $error("stalled result beat changed");

endmodule

bind laser_point_rotate_scale_blank lprsb_chk u_lprsb_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .x_out_i     (res_o.x_out),
  .y_out_i     (res_o.y_out),
  .red_out_i   (res_o.red_out),
  .green_out_i (res_o.green_out),
  .blue_out_i  (res_o.blue_out),
  .blanked_i   (res_o.blanked)
);

>>> bench/laser_point_rotate_scale_blank_test.sv
// Self-checking testbench for the laser point rotate, scale and blank block.
`timescale 1ns / 100ps

module laser_point_rotate_scale_blank_test
  import lprsb_pkg::*;
;

  localparam longint Q15One = 32768;
  localparam int WatchdogLimit = 2000;
  localparam int StallMax = 12;
  localparam int MaxReports = 40;
  // There is no register behind this index, so a write to it must change nothing.
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 3'd7;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic        blank;
  } point_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        blanked;
  } spot_t;

  logic clk;
  logic rst_n;

  lprsb_cfg_if cfg_if ();
  lprsb_pt_if  pt_if ();
  lprsb_res_if res_if ();

  laser_point_rotate_scale_blank i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if.sink),
    .pt_i   (pt_if.sink),
    .res_o  (res_if.source)
  );

  cfg_t  shadow_cfg;
  spot_t expected_spots[$];
  int    mismatches;
  int    idle_cycles;
  int    burst_left;
  int    gap_max;
  int    stall_pct;
  int    stall_left;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // One axis: scale about the screen middle, clamp to the screen, halve.
  function automatic logic [15:0] screen_axis(longint u2, longint scale);
    longint v;
    v = ((u2 - Mid2) * scale) / Q15One + Mid2;
    if (v < 0) v = 0;
    if (v > Full2) v = Full2;
    return 16'(v >>> 1);
  endfunction

  function automatic spot_t transform_point(cfg_t c, point_t p);
    longint cs, sn, cx, cy, dx, dy, rx, ry;
    spot_t  s;
    cs = $signed(c.cos_angle);
    sn = $signed(c.sin_angle);
    cx = $signed(c.center_x2);
    cy = $signed(c.center_y2);
    dx = 2 * longint'(p.x) - cx;
    dy = 2 * longint'(p.y) - cy;
    rx = (dx * cs) / Q15One - (dy * sn) / Q15One + cx;
    ry = (dx * sn) / Q15One + (dy * cs) / Q15One + cy;
    s.x = screen_axis(rx, $signed(c.scale_x));
    s.y = screen_axis(ry, $signed(c.scale_y));
    s.blanked = p.blank || s.x < VisMin || s.x > VisMax || s.y < VisMin || s.y > VisMax;
    s.red   = s.blanked ? 16'd0 : c.color_rgb[47:32];
    s.green = s.blanked ? 16'd0 : c.color_rgb[31:16];
    s.blue  = s.blanked ? 16'd0 : c.color_rgb[15:0];
    return s;
  endfunction

  task automatic check_field(string what, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Result checker: every result beat is matched against the oldest prediction.
  always @(posedge clk) begin
    spot_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_spots.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: unexpected result beat, expected none, actual x %0d y %0d",
                   $time, res_if.x_out, res_if.y_out);
      end else begin
        want = expected_spots.pop_front();
        check_field("x_out", want.x, res_if.x_out);
        check_field("y_out", want.y, res_if.y_out);
        check_field("red_out", want.red, res_if.red_out);
        check_field("green_out", want.green, res_if.green_out);
        check_field("blue_out", want.blue, res_if.blue_out);
        check_field("blanked", 16'(want.blanked), 16'(res_if.blanked));
      end
    end
  end

  always @(posedge clk) begin
    if ((pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no beat for %0d cycles", $time, WatchdogLimit);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver back-pressure: random stalls of random length at the current rate.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      res_if.ready <= 1'b0;
      stall_left--;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      res_if.ready <= 1'b0;
      stall_left = $urandom_range(StallMax - 1);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  task automatic send_point(point_t p);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(gap_max);
      burst_left = 1 + $urandom_range(29);
      if (gap > 0) begin
        @(negedge clk);
        pt_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    pt_if.valid    <= 1'b1;
    pt_if.x_in     <= p.x;
    pt_if.y_in     <= p.y;
    pt_if.blank_in <= p.blank;
    do @(posedge clk); while (!pt_if.ready);
    expected_spots.insert(expected_spots.size(), transform_point(shadow_cfg, p));
    burst_left--;
  endtask

  // Stops the point stream and waits until every predicted result has come back.
  task automatic drain_points();
    @(negedge clk);
    pt_if.valid <= 1'b0;
    burst_left = 0;
    while (expected_spots.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_COS:     shadow_cfg.cos_angle = data[16:0];
      CFG_SIN:     shadow_cfg.sin_angle = data[16:0];
      CFG_CENTERX: shadow_cfg.center_x2 = data[18:0];
      CFG_CENTERY: shadow_cfg.center_y2 = data[18:0];
      CFG_SCALEX:  shadow_cfg.scale_x   = data[16:0];
      CFG_SCALEY:  shadow_cfg.scale_y   = data[16:0];
      CFG_COLOR:   shadow_cfg.color_rgb = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Writes all registers; bits above each register's width carry junk.
  task automatic load_setting(cfg_t c);
    logic [CfgDataW-1:0] junk;
    drain_points();
    junk = 48'({$urandom, $urandom});
    write_reg(CFG_COS, {junk[47:17], c.cos_angle});
    junk = 48'({$urandom, $urandom});
    write_reg(CFG_SIN, {junk[47:17], c.sin_angle});
    junk = 48'({$urandom, $urandom});
    write_reg(CFG_CENTERX, {junk[47:19], c.center_x2});
    junk = 48'({$urandom, $urandom});
    write_reg(CFG_CENTERY, {junk[47:19], c.center_y2});
    junk = 48'({$urandom, $urandom});
    write_reg(CFG_SCALEX, {junk[47:17], c.scale_x});
    junk = 48'({$urandom, $urandom});
    write_reg(CFG_SCALEY, {junk[47:17], c.scale_y});
    write_reg(CFG_COLOR, c.color_rgb);
  endtask

  function automatic logic [15:0] pick_coord();
    logic [15:0] marks[11] = '{0, 1, 34, 35, 36, 32767, 32768, 65499, 65500, 65501, 65535};
    if ($urandom_range(99) < 60) return 16'($urandom);
    return marks[$urandom_range(10)] + 16'($urandom_range(4)) - 16'd2;
  endfunction

  function automatic logic [16:0] pick_factor(bit gentle);
    int v;
    case ($urandom_range(gentle ? 0 : 3))
      0: v = gentle ? 16384 + $urandom_range(16384) : $urandom_range(65536) - 32768;
      1: v = $urandom_range(1) ? 32768 : -32768;
      2: v = 0;
      default: return 17'($urandom);
    endcase
    return 17'(v);
  endfunction

  function automatic cfg_t pick_setting(bit gentle);
    cfg_t c;
    int   v;
    c.cos_angle = pick_factor(gentle);
    c.sin_angle = gentle ? 17'($urandom_range(32768) - 16384) : pick_factor(1'b0);
    c.scale_x   = pick_factor(gentle);
    c.scale_y   = pick_factor(gentle);
    if (gentle) begin
      c.center_x2 = 19'($urandom_range(40000) + 45535);
      c.center_y2 = 19'($urandom_range(40000) + 45535);
    end else begin
      v = $urandom_range(3) == 0 ? 196605 : $urandom_range(262140) - 65535;
      c.center_x2 = $urandom_range(7) == 0 ? 19'($urandom) : 19'(v);
      v = $urandom_range(3) == 0 ? -65535 : $urandom_range(262140) - 65535;
      c.center_y2 = $urandom_range(7) == 0 ? 19'($urandom) : 19'(v);
    end
    case ($urandom_range(5))
      0: c.color_rgb = '0;
      1: c.color_rgb = '1;
      default: c.color_rgb = 48'({$urandom, $urandom});
    endcase
    return c;
  endfunction

  // Identity transform after reset: corners, window edges and blank_in.
  task automatic test_reset_defaults();
    gap_max = 0;
    stall_pct = 0;
    send_point('{x: 16'd0, y: 16'd0, blank: 1'b0});
    send_point('{x: 16'd65535, y: 16'd65535, blank: 1'b0});
    send_point('{x: 16'd0, y: 16'd65535, blank: 1'b0});
    send_point('{x: 16'd65535, y: 16'd0, blank: 1'b0});
    send_point('{x: 16'd35, y: 16'd65500, blank: 1'b0});
    send_point('{x: 16'd34, y: 16'd1000, blank: 1'b0});
    send_point('{x: 16'd65500, y: 16'd35, blank: 1'b0});
    send_point('{x: 16'd1000, y: 16'd65501, blank: 1'b0});
    send_point('{x: 16'd32767, y: 16'd32768, blank: 1'b0});
    send_point('{x: 16'd32767, y: 16'd32768, blank: 1'b1});
  endtask

  // Extreme factors, extreme centers, and patterns beyond the stated ranges.
  task automatic test_config_extremes();
    cfg_t c;
    c = '{cos_angle: -17'sd32768, sin_angle: 17'sd32768, center_x2: 19'sd196605,
          center_y2: -19'sd65535, scale_x: -17'sd32768, scale_y: 17'sd0, color_rgb: '1};
    repeat (3) begin
      load_setting(c);
      send_point('{x: 16'd0, y: 16'd0, blank: 1'b0});
      send_point('{x: 16'd65535, y: 16'd65535, blank: 1'b0});
      send_point('{x: 16'd32768, y: 16'd0, blank: 1'b1});
      send_point('{x: 16'd0, y: 16'd65535, blank: 1'b0});
      if (c.cos_angle == -17'sd32768) begin
        c = '{cos_angle: 17'sd0, sin_angle: -17'sd32768, center_x2: -19'sd65535,
              center_y2: 19'sd196605, scale_x: 17'sd32768, scale_y: -17'sd32768,
              color_rgb: 48'({$urandom, $urandom})};
      end else begin
        c = '{cos_angle: 17'h1ffff, sin_angle: 17'h0ffff, center_x2: 19'h40000,
              center_y2: 19'h3ffff, scale_x: 17'h10000, scale_y: 17'h0ffff, color_rgb: '0};
      end
    end
  endtask

  task automatic test_spare_index();
    load_setting('{cos_angle: 17'sd32768, sin_angle: 17'sd0, center_x2: 19'sd65535,
                   center_y2: 19'sd65535, scale_x: 17'sd32768, scale_y: 17'sd32768,
                   color_rgb: 48'({$urandom, $urandom})});
    write_reg(CfgIdxSpare, 48'({$urandom, $urandom}));
    send_point('{x: 16'd40000, y: 16'd20000, blank: 1'b0});
    send_point('{x: 16'd65535, y: 16'd65535, blank: 1'b1});
  endtask

  task automatic test_random_points();
    point_t p;
    for (int phase = 0; phase < 14; phase++) begin
      load_setting(pick_setting(phase % 2 == 0));
      if (phase % 5 == 3) write_reg(CfgIdxSpare, 48'({$urandom, $urandom}));
      gap_max   = (phase == 0) ? 0 : (phase % 3 == 0 ? 0 : (phase % 3 == 1 ? 3 : 15));
      stall_pct = (phase == 0) ? 0 : (phase % 4 == 0 ? 0 : (phase % 4 == 1 ? 10 : 40));
      repeat (100) begin
        p.x = pick_coord();
        p.y = pick_coord();
        p.blank = $urandom_range(3) == 0;
        send_point(p);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_COS;
    cfg_if.data = '0;
    pt_if.valid = 1'b0;
    pt_if.x_in = '0;
    pt_if.y_in = '0;
    pt_if.blank_in = 1'b0;
    res_if.ready = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    burst_left = 0;
    gap_max = 0;
    stall_pct = 0;
    stall_left = 0;
    shadow_cfg = '{cos_angle: 17'sd32768, sin_angle: 17'sd0, center_x2: 19'sd65535,
                   center_y2: 19'sd65535, scale_x: 17'sd32768, scale_y: 17'sd32768,
                   color_rgb: '1};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_config_extremes();
    test_spare_index();
    test_random_points();

    drain_points();
    repeat (8) @(posedge clk);
    if (expected_spots.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
